>>> design/mrc_pkg.sv
// ----------------------------------------------------------------------------
// Marker record checker package
// Record layout constants, shared types and the byte-wide CRC-32 update.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int unsigned RECORD_BYTES   = 24;
	localparam int unsigned CRC_SPAN_BYTES = 20;
	localparam int unsigned COUNT_W        = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd31;
	localparam logic [COUNT_W-1:0] COUNT_RECORD  = 5'(RECORD_BYTES);
	localparam logic [COUNT_W-1:0] COUNT_CRC     = 5'(CRC_SPAN_BYTES);
	localparam logic [COUNT_W-1:0] POS_VERSION   = 5'd4;
	localparam logic [COUNT_W-1:0] POS_SAVE_ID   = 5'd8;
	localparam logic [COUNT_W-1:0] POS_FLAGS     = 5'd16;
	localparam logic [COUNT_W-1:0] POS_CHECKSUM  = 5'd20;

	localparam logic [31:0] MARKER_MAGIC   = 32'h314E_5854;
	localparam logic [31:0] MARKER_VERSION = 32'd1;
	localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
	localparam logic [31:0] MASK_RESET     = 32'd31;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		logic        record_valid;
		logic [63:0] save_id;
		logic [31:0] flag_bits;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] crc;
		crc = crc_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (crc[0]) begin
				crc = (crc >> 1) ^ CRC_POLY;
			end else begin
				crc = crc >> 1;
			end
		end
		return crc;
	endfunction

endpackage

>>> design/mrc_in_reg.sv
// ----------------------------------------------------------------------------
// Marker record checker input register
// Holds one accepted byte beat until the record logic consumes it.
// ----------------------------------------------------------------------------
module mrc_in_reg
	import mrc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  beat_t beat_in,
	input  logic  advance,
	output logic  valid_s1,
	output beat_t beat_s1
);

	logic load;

	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s1 <= beat_in;
		end
	end

endmodule

>>> design/mrc_accum.sv
// ----------------------------------------------------------------------------
// Marker record checker accumulator
// Collects record fields and the running CRC, and judges the record on its
// last byte.
// ----------------------------------------------------------------------------
module mrc_accum
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] flag_mask,
	input  logic        valid_s1,
	input  beat_t       beat_s1,
	input  logic        out_free,
	output logic        advance,
	output logic        result_load,
	output result_t     result
);

	logic [COUNT_W-1:0] count_q, count_n;
	logic [31:0]        crc_q, crc_n;
	logic [31:0]        magic_q, magic_n;
	logic [31:0]        version_q, version_n;
	logic [63:0]        save_id_q, save_id_n;
	logic [31:0]        flags_q, flags_n;
	logic [31:0]        checksum_q, checksum_n;
	logic [COUNT_W-1:0] pos;
	logic [31:0]        lane32;
	logic [63:0]        lane64;
	logic               ok;

	assign advance     = valid_s1 && (!beat_s1.last_byte || out_free);
	assign result_load = advance && beat_s1.last_byte;
	assign pos         = count_q;
	assign lane32      = {24'd0, beat_s1.data_byte} << {pos[1:0], 3'b000};
	assign lane64      = {56'd0, beat_s1.data_byte} << {pos[2:0], 3'b000};

	always_comb begin
		magic_n    = magic_q;
		version_n  = version_q;
		save_id_n  = save_id_q;
		flags_n    = flags_q;
		checksum_n = checksum_q;
		if (pos < POS_VERSION) begin
			magic_n = magic_q | lane32;
		end else if (pos < POS_SAVE_ID) begin
			version_n = version_q | lane32;
		end else if (pos < POS_FLAGS) begin
			save_id_n = save_id_q | lane64;
		end else if (pos < POS_CHECKSUM) begin
			flags_n = flags_q | lane32;
		end else if (pos < COUNT_RECORD) begin
			checksum_n = checksum_q | lane32;
		end
		crc_n   = (pos < COUNT_CRC) ? crc_byte(crc_q, beat_s1.data_byte) : crc_q;
		count_n = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;
	end

	always_comb begin
		ok = (count_n == COUNT_RECORD) && (magic_n == MARKER_MAGIC)
			&& (version_n == MARKER_VERSION) && (save_id_n != 64'd0)
			&& ((flags_n & ~flag_mask) == 32'd0) && ((crc_n ^ CRC_INIT) == checksum_n);
		result.record_valid = ok;
		result.save_id      = ok ? save_id_n : 64'd0;
		result.flag_bits    = ok ? flags_n : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			crc_q      <= CRC_INIT;
			magic_q    <= '0;
			version_q  <= '0;
			save_id_q  <= '0;
			flags_q    <= '0;
			checksum_q <= '0;
		end else if (advance) begin
			if (beat_s1.last_byte) begin
				count_q    <= '0;
				crc_q      <= CRC_INIT;
				magic_q    <= '0;
				version_q  <= '0;
				save_id_q  <= '0;
				flags_q    <= '0;
				checksum_q <= '0;
			end else begin
				count_q    <= count_n;
				crc_q      <= crc_n;
				magic_q    <= magic_n;
				version_q  <= version_n;
				save_id_q  <= save_id_n;
				flags_q    <= flags_n;
				checksum_q <= checksum_n;
			end
		end
	end

endmodule

>>> design/mrc_out_reg.sv
// ----------------------------------------------------------------------------
// Marker record checker output register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module mrc_out_reg
	import mrc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    result_load,
	input  result_t result,
	output logic    out_free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result_q
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (result_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q <= result;
		end
	end

endmodule

>>> design/marker_record_checker.sv
// Throughput: one byte beat per cycle, sustained, while the output side drains.
// The result is registered: the last byte's beat passes the input register and the
// record logic into the result register, which offers it; a full one stalls the input.
// Reset clears the record state, sets the mask register to 31 and empties both registers.
// ----------------------------------------------------------------------------
// Marker record checker
// Validates a 24-byte little-endian marker record with a CRC-32 trailer.
// ----------------------------------------------------------------------------
module marker_record_checker
	import mrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] allowed_flag_mask,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        record_valid,
	output logic [63:0] save_id,
	output logic [31:0] flag_bits
);

	logic [31:0] mask_q;
	beat_t       beat_in;
	beat_t       beat_s1;
	logic        valid_s1;
	logic        advance;
	logic        out_free;
	logic        result_load;
	result_t     result;
	result_t     result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mask_q <= allowed_flag_mask;
		end
	end

	assign beat_in.data_byte = data_byte;
	assign beat_in.last_byte = last_byte;

	mrc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.beat_in  (beat_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	mrc_accum u_accum (
		.clk         (clk),
		.arst_n      (arst_n),
		.flag_mask   (mask_q),
		.valid_s1    (valid_s1),
		.beat_s1     (beat_s1),
		.out_free    (out_free),
		.advance     (advance),
		.result_load (result_load),
		.result      (result)
	);

	mrc_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.result_load (result_load),
		.result      (result),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_q    (result_q)
	);

	assign record_valid = result_q.record_valid;
	assign save_id      = result_q.save_id;
	assign flag_bits    = result_q.flag_bits;

endmodule

>>> test/marker_record_checker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Marker record checker testbench
// Streams whole, damaged, short, overlong and random byte records into the
// checker under random input gaps and output stalls, and compares every
// verdict beat against a byte-level model of the record fields and CRC-32.
// The flag mask is rewritten between record groups while the checker is idle.
// ----------------------------------------------------------------------------
module marker_record_checker_tb;
	import mrc_pkg::*;

	localparam int DRAIN_CYCLES   = 4;
	localparam int IDLE_LIMIT     = 2000;
	localparam int RANDOM_BYTES   = 1050;
	localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
	localparam logic [63:0] ALL_ONES64 = 64'hFFFF_FFFF_FFFF_FFFF;

	typedef enum int {
		REC_GOOD,
		REC_BAD_MAGIC,
		REC_BAD_VERSION,
		REC_BAD_CRC,
		REC_SHORT,
		REC_LONG,
		REC_NOISE
	} rec_kind_t;

	class record_verdict_sb;
		logic [31:0] flag_mask;
		logic [4:0]  pos;
		logic [31:0] crc;
		logic [31:0] magic;
		logic [31:0] version;
		logic [63:0] sid;
		logic [31:0] flags;
		logic [31:0] checksum;
		result_t     pending_verdicts[$];
		int          errors;

		function new();
			flag_mask = MASK_RESET;
			errors = 0;
			clear();
		endfunction

		function void clear();
			pos = '0;
			crc = CRC_INIT;
			magic = '0;
			version = '0;
			sid = '0;
			flags = '0;
			checksum = '0;
		endfunction

		static function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
			logic fb;
			for (int i = 0; i < 8; i++) begin
				fb = c[0] ^ b[i];
				c = {1'b0, c[31:1]};
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
			return c;
		endfunction

		// Notes one accepted byte beat; the last byte of a record yields a verdict.
		function void take_byte(logic [7:0] b, logic l);
			int unsigned p;
			logic        ok;
			result_t     v;
			p = pos;
			if (p < RECORD_BYTES) begin
				if (p < POS_VERSION) begin
					magic[8*p +: 8] = b;
				end else if (p < POS_SAVE_ID) begin
					version[8*(p-4) +: 8] = b;
				end else if (p < POS_FLAGS) begin
					sid[8*(p-8) +: 8] = b;
				end else if (p < POS_CHECKSUM) begin
					flags[8*(p-16) +: 8] = b;
				end else begin
					checksum[8*(p-20) +: 8] = b;
				end
			end
			if (p < CRC_SPAN_BYTES) begin
				crc = crc_update(crc, b);
			end
			if (pos != COUNT_MAX) begin
				pos = pos + 5'd1;
			end
			if (!l) begin
				return;
			end
			ok = (pos == COUNT_RECORD) && (magic == MARKER_MAGIC)
				&& (version == MARKER_VERSION) && (sid != '0)
				&& ((flags & ~flag_mask) == '0) && (~crc == checksum);
			v.record_valid = ok;
			v.save_id = ok ? sid : '0;
			v.flag_bits = ok ? flags : '0;
			pending_verdicts.push_back(v);
			clear();
		endfunction

		function void match_verdict(logic rv, logic [63:0] id, logic [31:0] fl);
			result_t want;
			if (pending_verdicts.size() == 0) begin
				$error("verdict beat with none pending: record_valid %0d save_id %0h flag_bits %0h",
					rv, id, fl);
				errors++;
				return;
			end
			want = pending_verdicts.pop_front();
			if (rv !== want.record_valid) begin
				$error("record_valid: expected %0d, got %0d", want.record_valid, rv);
				errors++;
			end
			if (id !== want.save_id) begin
				$error("save_id: expected %0h, got %0h", want.save_id, id);
				errors++;
			end
			if (fl !== want.flag_bits) begin
				$error("flag_bits: expected %0h, got %0h", want.flag_bits, fl);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] allowed_flag_mask;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_stall;
	logic        record_valid;
	logic [63:0] save_id;
	logic [31:0] flag_bits;

	record_verdict_sb sb;
	bit               quiet_run;
	int               bytes_sent;
	logic [31:0]      cur_mask;

	marker_record_checker i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.allowed_flag_mask (allowed_flag_mask),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.data_byte         (data_byte),
		.last_byte         (last_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.record_valid      (record_valid),
		.save_id           (save_id),
		.flag_bits         (flag_bits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 15);
		end
		return $urandom_range(30, 80);
	endfunction

	function automatic logic [63:0] pick_save_id();
		logic [63:0] id;
		int          r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			id = 64'd1;
		end else if (r == 1) begin
			id = ALL_ONES64;
		end else if (r == 2) begin
			id = 64'd1 << $urandom_range(0, 63);
		end else begin
			id = {$urandom, $urandom};
			if (id == '0) begin
				id = 64'd1;
			end
		end
		return id;
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic l);
		int gap;
		gap = quiet_run ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		sb.take_byte(b, l);
		bytes_sent++;
	endtask

	// len_arg sets the kept length of a short record, the extra bytes of a
	// long one or the size of a noise record; zero picks it at random.
	task automatic send_record(input rec_kind_t kind, input logic [63:0] sid,
			input logic [31:0] flags, input int len_arg);
		logic [7:0]  bytes[$];
		logic [31:0] magic;
		logic [31:0] version;
		logic [31:0] crc;
		int          n;
		magic = MARKER_MAGIC;
		version = MARKER_VERSION;
		if (kind == REC_BAD_MAGIC) begin
			magic = magic ^ (32'd1 << $urandom_range(0, 31));
		end
		if (kind == REC_BAD_VERSION) begin
			version = $urandom_range(0, 1) ? 32'd0 : 32'($urandom);
			if (version == MARKER_VERSION) begin
				version = 32'd2;
			end
		end
		for (int i = 0; i < 4; i++) bytes.push_back(magic[8*i +: 8]);
		for (int i = 0; i < 4; i++) bytes.push_back(version[8*i +: 8]);
		for (int i = 0; i < 8; i++) bytes.push_back(sid[8*i +: 8]);
		for (int i = 0; i < 4; i++) bytes.push_back(flags[8*i +: 8]);
		crc = CRC_INIT;
		foreach (bytes[i]) crc = record_verdict_sb::crc_update(crc, bytes[i]);
		crc = ~crc;
		if (kind == REC_BAD_CRC) begin
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		end
		for (int i = 0; i < 4; i++) bytes.push_back(crc[8*i +: 8]);
		case (kind)
			REC_SHORT: begin
				n = (len_arg > 0) ? len_arg : $urandom_range(1, RECORD_BYTES - 1);
				while (bytes.size() > n) void'(bytes.pop_back());
			end
			REC_LONG: begin
				n = (len_arg > 0) ? len_arg
					: ($urandom_range(0, 3) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 7));
				repeat (n) bytes.push_back(8'($urandom));
			end
			REC_NOISE: begin
				n = (len_arg > 0) ? len_arg : $urandom_range(1, 30);
				bytes.delete();
				repeat (n) bytes.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
		foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic wait_idle(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_verdicts.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_mask(input logic [31:0] m);
		wait_idle(DRAIN_CYCLES);
		cfg_valid <= 1'b1;
		allowed_flag_mask <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.flag_mask = m;
	endtask

	initial begin : stall_gen
		int hold;
		hold = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (quiet_run || $urandom_range(0, 2) != 0) begin
				out_stall <= 1'b0;
				hold = $urandom_range(0, 8);
			end else begin
				out_stall <= 1'b1;
				hold = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.match_verdict(record_valid, save_id, flag_bits);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("** marker_record_checker: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int          records;
		int          r;
		int          bit_i;
		rec_kind_t   kind;
		logic [63:0] sid;
		logic [31:0] flags;
		sb = new();
		quiet_run = 1'b0;
		bytes_sent = 0;
		cur_mask = MASK_RESET;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		allowed_flag_mask <= '0;
		in_valid <= 1'b0;
		data_byte <= '0;
		last_byte <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset mask: well-formed record, then each way a record can fail.
		send_record(REC_GOOD, 64'h0123_4567_89AB_CDEF, MASK_RESET, 0);
		send_record(REC_SHORT, 64'd1, 32'd0, 1);
		send_record(REC_GOOD, 64'd1, 32'd0, 0);
		send_record(REC_GOOD, 64'd0, 32'd3, 0);
		send_record(REC_GOOD, 64'h55, 32'd32, 0);
		send_record(REC_BAD_MAGIC, 64'h77, 32'd1, 0);
		send_record(REC_BAD_VERSION, 64'h77, 32'd1, 0);
		send_record(REC_BAD_CRC, 64'h77, 32'd1, 0);
		send_record(REC_LONG, 64'h99, 32'd2, 36);
		send_record(REC_SHORT, 64'h99, 32'd2, RECORD_BYTES - 1);

		cur_mask = '0;
		write_mask(cur_mask);
		send_record(REC_GOOD, pick_save_id(), 32'd0, 0);
		send_record(REC_GOOD, pick_save_id(), 32'd1, 0);

		cur_mask = ALL_ONES32;
		write_mask(cur_mask);
		send_record(REC_GOOD, ALL_ONES64, ALL_ONES32, 0);
		send_record(REC_NOISE, 64'd0, 32'd0, 28);

		records = 0;
		while (bytes_sent < RANDOM_BYTES) begin
			if (records % 9 == 8) begin
				r = $urandom_range(0, 4);
				cur_mask = (r == 0) ? 32'd0 : (r == 1) ? ALL_ONES32
					: (r == 2) ? MASK_RESET : 32'($urandom);
				write_mask(cur_mask);
			end else if (records % 5 == 4) begin
				wait_idle(0);
			end
			records++;
			quiet_run = ($urandom_range(0, 7) == 0);
			sid = pick_save_id();
			flags = ($urandom_range(0, 4) == 0) ? cur_mask : (32'($urandom) & cur_mask);
			r = $urandom_range(0, 99);
			kind = REC_GOOD;
			if (r < 55) begin
				kind = REC_GOOD;
			end else if (r < 62) begin
				sid = '0;
			end else if (r < 70) begin
				if (cur_mask != ALL_ONES32) begin
					do bit_i = $urandom_range(0, 31); while (cur_mask[bit_i]);
					flags = flags | (32'd1 << bit_i);
				end
			end else if (r < 75) begin
				kind = REC_BAD_MAGIC;
			end else if (r < 80) begin
				kind = REC_BAD_VERSION;
			end else if (r < 86) begin
				kind = REC_BAD_CRC;
			end else if (r < 92) begin
				kind = REC_SHORT;
			end else if (r < 96) begin
				kind = REC_LONG;
			end else begin
				kind = REC_NOISE;
			end
			send_record(kind, sid, flags, 0);
		end
		quiet_run = 1'b0;

		wait_idle(DRAIN_CYCLES);
		if (sb.errors == 0) begin
			$display("** marker_record_checker: PASSED **");
		end else begin
			$display("** marker_record_checker: FAILED **");
		end
		$finish;
	end

endmodule
